// File: design/tsel_pkg.sv
// Shared types and constants of the tracklet hit segment selector.
`timescale 1ns / 1ps

package tsel_pkg;

  // Rows at or beyond this index carry no usable hit.
  localparam int MaxRows = 160;

  // Default depth of the queue between front and back.
  localparam int QueueDepth = 4;

  // Register reset values
  localparam logic [7:0] MinHitsRst   = 8'd10;
  localparam logic [3:0] MaxRowGapRst = 4'd4;
  localparam logic [7:0] SharedDivRst = 8'd10;

  typedef enum logic [1:0] {
    CfgMinHits   = 2'd0,
    CfgMaxRowGap = 2'd1,
    CfgSharedDiv = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KindHit     = 2'd0,
    KindCommit  = 2'd1,
    KindDiscard = 2'd2
  } kind_e;

  typedef struct packed {
    logic        tracklet_start;
    logic [15:0] tracklet_id;
    logic [7:0]  tracklet_hits;
    logic [7:0]  row;
    logic [7:0]  last_row;
    logic        hit_present;
    logic [15:0] hit_index;
    logic [30:0] hit_weight;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  hit_row;
    logic [15:0] accepted_hit;
    logic [15:0] track_index;
    logic [23:0] first_hit_id;
    logic [7:0]  hit_count;
    logic        last;
  } out_word_t;

  // One queue entry holds every result of one input word.
  typedef struct packed {
    out_word_t res0;
    out_word_t res1;
    logic      two;
  } q_entry_t;

endpackage

// File: design/tsel_front.sv
// Front end: config registers, segment state and per-row result forming.
`timescale 1ns / 1ps

module tsel_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsel_pkg::in_word_t in_word_i,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              full_i,
  output logic              push_o,
  output tsel_pkg::q_entry_t push_entry_o
);
  import tsel_pkg::*;

  localparam logic [8:0] MaxRowsW = 9'(MaxRows);

  logic [7:0]  min_hits_q, shared_div_q;
  logic [3:0]  max_gap_q;
  logic [7:0]  seg_q, seg_d, sh_q, sh_d;
  logic [4:0]  gap_q, gap_d;
  logic        stop_q, stop_d;
  logic [23:0] own_q, own_d;
  logic [15:0] trk_q, trk_d;
  logic [23:0] hcnt_q, hcnt_d;

  logic [7:0]  seg_e, sh_e, seg_n;
  logic [4:0]  gap_e, gap_n;
  logic        stop_e, own_ok, share_ok, hit_ok, close, commit, drop;
  logic [15:0] share_prod;
  logic [8:0]  reach;
  out_word_t   hit_res, close_res;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hits_q   <= MinHitsRst;
      max_gap_q    <= MaxRowGapRst;
      shared_div_q <= SharedDivRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMinHits:   min_hits_q   <= cfg_data_i;
        CfgMaxRowGap: max_gap_q    <= cfg_data_i[3:0];
        CfgSharedDiv: shared_div_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    // start of tracklet clears the segment before the row is looked at
    seg_e  = in_word_i.tracklet_start ? 8'd0 : seg_q;
    sh_e   = in_word_i.tracklet_start ? 8'd0 : sh_q;
    gap_e  = in_word_i.tracklet_start ? 5'd0 : gap_q;
    own_d  = in_word_i.tracklet_start ?
             {in_word_i.tracklet_hits, in_word_i.tracklet_id} : own_q;
    stop_e = in_word_i.tracklet_start ? (in_word_i.tracklet_hits == 8'd0) : stop_q;

    reach = {1'b0, in_word_i.last_row - in_word_i.row} + {1'b0, seg_e};
    drop  = (in_word_i.row > in_word_i.last_row) || (reach < {1'b0, min_hits_q});

    own_ok     = in_word_i.hit_weight <= {7'd0, own_d};
    share_prod = 16'(sh_e) * 16'(shared_div_q);
    share_ok   = share_prod < {8'd0, seg_e};
    hit_ok     = !stop_e && !drop && in_word_i.hit_present &&
                 ({1'b0, in_word_i.row} < MaxRowsW) && (own_ok || share_ok);

    seg_n = seg_e + {7'd0, hit_ok};
    gap_n = hit_ok ? 5'd0 : gap_e + 5'd1;
    close = !stop_e && !drop &&
            ((gap_n > {1'b0, max_gap_q}) || (in_word_i.row == in_word_i.last_row));
    commit = seg_n >= min_hits_q;

    seg_d  = seg_e;
    sh_d   = sh_e;
    gap_d  = gap_e;
    stop_d = stop_e;
    trk_d  = trk_q;
    hcnt_d = hcnt_q;
    if (!stop_e) begin
      if (drop) begin
        stop_d = 1'b1;
      end else if (close) begin
        seg_d = 8'd0;
        sh_d  = 8'd0;
        gap_d = 5'd0;
        if (in_word_i.row == in_word_i.last_row) stop_d = 1'b1;
        if (commit) begin
          trk_d  = trk_q + 16'd1;
          hcnt_d = hcnt_q + {16'd0, seg_n};
        end
      end else begin
        seg_d = seg_n;
        sh_d  = sh_e + {7'd0, hit_ok && !own_ok};
        gap_d = gap_n;
      end
    end

    hit_res              = '0;
    hit_res.kind         = KindHit;
    hit_res.hit_row      = in_word_i.row;
    hit_res.accepted_hit = in_word_i.hit_index;
    hit_res.last         = !close;

    close_res           = '0;
    close_res.kind      = commit ? KindCommit : KindDiscard;
    close_res.hit_count = seg_n;
    close_res.last      = 1'b1;
    if (commit) begin
      close_res.track_index  = trk_q;
      close_res.first_hit_id = hcnt_q;
    end

    push_entry_o.res0 = hit_ok ? hit_res : close_res;
    push_entry_o.res1 = close_res;
    push_entry_o.two  = hit_ok && close;
  end

  assign push_o = accept && (hit_ok || close);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= '0;
      sh_q   <= '0;
      gap_q  <= '0;
      stop_q <= 1'b0;
      own_q  <= '0;
      trk_q  <= '0;
      hcnt_q <= '0;
    end else if (accept) begin
      seg_q  <= seg_d;
      sh_q   <= sh_d;
      gap_q  <= gap_d;
      stop_q <= stop_d;
      own_q  <= own_d;
      trk_q  <= trk_d;
      hcnt_q <= hcnt_d;
    end
  end

endmodule

// File: design/tsel_queue.sv
// Short FIFO of result entries between front and back.
`timescale 1ns / 1ps

module tsel_queue #(
  parameter int Depth = tsel_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tsel_pkg::q_entry_t push_entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tsel_pkg::q_entry_t head_o
);
  import tsel_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not follow push");

endmodule

// File: design/tsel_back.sv
// Back end: splits queue entries into single result words on the output.
`timescale 1ns / 1ps

module tsel_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tsel_pkg::q_entry_t  q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsel_pkg::out_word_t out_word_o
);
  import tsel_pkg::*;

  out_word_t out_q, sec_q;
  logic      out_vld_q, sec_vld_q;
  logic      load;

  // output slot free now or freed this cycle
  assign load    = !out_vld_q || out_ready_i;
  assign q_pop_o = load && !sec_vld_q && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_vld_q) begin
        out_q <= sec_q;
      end else if (q_valid_i) begin
        out_q <= q_head_i.res0;
        sec_q <= q_head_i.res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_vld_q <= 1'b0;
    end else if (load) begin
      if (sec_vld_q) begin
        out_vld_q <= 1'b1;
        sec_vld_q <= 1'b0;
      end else begin
        out_vld_q <= q_valid_i;
        sec_vld_q <= q_valid_i && q_head_i.two;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_sec_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> out_vld_q) else $error("second result without first");

  a_no_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> !q_pop_o) else $error("pop while second result pending");

  a_sec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> (out_vld_q && !out_q.last && sec_q.last))
    else $error("pair of results with wrong last flags");

endmodule

// File: design/tracklet_hit_segment_selector.sv
// Top level of the tracklet hit segment selector.
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | in_word_i  (in_word_t)
//  out     | output    | out_valid_o/out_ready_i | out_word_o (out_word_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One input word is taken per cycle while the result queue has room; all
//  segment state updates in that same cycle in the front end.
//  The back end drives one result word per cycle while out_ready_i is high,
//  so a row's hit and close go out in turn; QueueDepth entries of slack.
//  Output stalls reach the input only once the queue is full.
//  rst_ni is asynchronous: registers return to defaults, counters to zero,
//  no clearing pass. Config writes are always taken (cfg_ready_o is high).

module tracklet_hit_segment_selector #(
  parameter int QueueDepth = tsel_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tsel_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsel_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import tsel_pkg::*;

  logic     push, full, pop, q_valid;
  q_entry_t push_entry, q_head;

  assign cfg_ready_o = 1'b1;

  // Front: classifies each row and forms up to two results
  tsel_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Queue decouples the row rate from the result rate
  tsel_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  // Back: one result word per cycle into the output register unless out_ready_i stalls it
  tsel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: bench/tb_tracklet_hit_segment_selector.sv
// Self-checking testbench for the tracklet hit segment selector.
`timescale 1ns / 1ps

module tb_tracklet_hit_segment_selector;
  import tsel_pkg::*;

  localparam int IdlePct     = 17;    // chance per cycle that a side idles
  localparam int HoldCycles  = 80;    // long receiver hold-off, fills the block
  localparam int DrainCycles = 16;    // extra wait in wait_idle once nothing is owed, with margin
  localparam int StallLimit  = 1000;  // cycles without any handshake before giving up
  localparam int PrintLimit  = 40;    // only the first mismatches get a line

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  tracklet_hit_segment_selector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Selector state as the testbench sees it. Register copies change only
  // while the block is idle; segment state moves with every accepted row.
  // ---------------------------------------------------------------------------
  logic [7:0]  sel_min_hits   = MinHitsRst;
  logic [3:0]  sel_max_gap    = MaxRowGapRst;
  logic [7:0]  sel_shared_div = SharedDivRst;

  logic [7:0]  seg_hits     = '0;
  logic [7:0]  shared_cnt   = '0;
  logic [4:0]  gap_cnt      = '0;
  logic        halted       = 1'b0;
  logic [30:0] trk_weight   = '0;
  logic [15:0] track_num    = '0;
  logic [23:0] hit_offset   = '0;

  in_word_t  row_q[$];             // rows waiting for the driver
  out_word_t expected_results[$];  // results the selector still owes us

  int rows_queued   = 0;
  int rows_accepted = 0;
  int cfg_writes    = 0;
  int hits_seen     = 0;
  int commits_seen  = 0;
  int discards_seen = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  bit steady        = 1'b0;  // both sides stop idling while set

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Works out the results of one accepted row and updates the segment state.
  function automatic void predict_row(input in_word_t w);
    out_word_t res[2];
    int        n;
    bit        own;
    bit        share_ok;
    n = 0;
    res[0] = '0;
    res[1] = '0;

    // A new tracklet clears the segment before its first row is looked at.
    if (w.tracklet_start) begin
      seg_hits   = '0;
      shared_cnt = '0;
      gap_cnt    = '0;
      trk_weight = {7'd0, w.tracklet_hits, w.tracklet_id};
      halted     = (w.tracklet_hits == 8'd0);
    end
    if (halted) return;

    // Past the last row, or too few rows left to ever reach the minimum.
    if (w.row > w.last_row ||
        int'(w.last_row) - int'(w.row) + int'(seg_hits) < int'(sel_min_hits)) begin
      halted = 1'b1;
      return;
    end

    gap_cnt = gap_cnt + 5'd1;

    // Hits on rows at or past MaxRows count as missing.
    if (w.hit_present && int'(w.row) < MaxRows) begin
      own      = (w.hit_weight <= trk_weight);
      share_ok = int'(shared_cnt) * int'(sel_shared_div) < int'(seg_hits);
      if (own || share_ok) begin
        gap_cnt             = '0;
        res[n].kind         = KindHit;
        res[n].hit_row      = w.row;
        res[n].accepted_hit = w.hit_index;
        n++;
        seg_hits = seg_hits + 8'd1;
        if (!own) shared_cnt = shared_cnt + 8'd1;
      end
    end

    // Close on a gap that is too long or on the last row; empty segments too.
    if (gap_cnt > {1'b0, sel_max_gap} || w.row == w.last_row) begin
      if (seg_hits >= sel_min_hits) begin
        res[n].kind         = KindCommit;
        res[n].track_index  = track_num;
        res[n].first_hit_id = hit_offset;
        res[n].hit_count    = seg_hits;
        track_num  = track_num + 16'd1;
        hit_offset = hit_offset + {16'd0, seg_hits};
      end else begin
        res[n].kind      = KindDiscard;
        res[n].hit_count = seg_hits;
      end
      n++;
      seg_hits   = '0;
      shared_cnt = '0;
      gap_cnt    = '0;
      if (w.row == w.last_row) halted = 1'b1;
    end

    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predicts on acceptance, then decides what the next cycle offers.
  // in_valid gets exactly one nonblocking write per edge at most.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predict_row(in_word);
        rows_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (row_q.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          in_word  <= row_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure, plus a long hold-off whenever one is asked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holds_done < holds_asked && hold_left == 0) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Monitor: every result word against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      case (out_word.kind)
        KindHit:     hits_seen++;
        KindCommit:  commits_seen++;
        KindDiscard: discards_seen++;
        default: ;
      endcase
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected (kind %0h)",
                                  results_seen, out_word.kind));
      end else begin
        want = expected_results.pop_front();
        if (out_word.kind !== want.kind)
          report_mismatch($sformatf("result %0d kind %0h, want %0h",
                                    results_seen, out_word.kind, want.kind));
        if (out_word.hit_row !== want.hit_row)
          report_mismatch($sformatf("result %0d hit_row %0h, want %0h",
                                    results_seen, out_word.hit_row, want.hit_row));
        if (out_word.accepted_hit !== want.accepted_hit)
          report_mismatch($sformatf("result %0d accepted_hit %0h, want %0h",
                                    results_seen, out_word.accepted_hit, want.accepted_hit));
        if (out_word.track_index !== want.track_index)
          report_mismatch($sformatf("result %0d track_index %0h, want %0h",
                                    results_seen, out_word.track_index, want.track_index));
        if (out_word.first_hit_id !== want.first_hit_id)
          report_mismatch($sformatf("result %0d first_hit_id %0h, want %0h",
                                    results_seen, out_word.first_hit_id, want.first_hit_id));
        if (out_word.hit_count !== want.hit_count)
          report_mismatch($sformatf("result %0d hit_count %0h, want %0h",
                                    results_seen, out_word.hit_count, want.hit_count));
        if (out_word.last !== want.last)
          report_mismatch($sformatf("result %0d last %0b, want %0b",
                                    results_seen, out_word.last, want.last));
      end
    end
  end

  // Watchdog: a missing result or a hung handshake ends up here.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results still owed",
               StallLimit, expected_results.size());
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_row(input in_word_t w);
    row_q.push_back(w);
    rows_queued++;
  endfunction

  function automatic void directed_row(input bit start, input logic [15:0] tid,
                                       input logic [7:0] thits, input logic [7:0] row,
                                       input logic [7:0] lrow, input bit present,
                                       input logic [15:0] hidx, input logic [30:0] hw);
    in_word_t w;
    w.tracklet_start = start;
    w.tracklet_id    = tid;
    w.tracklet_hits  = thits;
    w.row            = row;
    w.last_row       = lrow;
    w.hit_present    = present;
    w.hit_index      = hidx;
    w.hit_weight     = hw;
    queue_row(w);
  endfunction

  // One tracklet: consecutive rows from 'first', 'n_sent' of them but none past
  // row 255, all claiming 'lrow' as last row (so short sends are cut-off
  // tracklets and long ones run past the end). The tracklet id and hit count
  // fields are noise on later rows, since the block ignores them there.
  function automatic void add_tracklet(input int first, input int n_sent, input int lrow,
                                       input int miss_pct, input int foreign_pct);
    in_word_t    w;
    logic [7:0]  thits;
    logic [15:0] tid;
    logic [30:0] wt;
    thits = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
    tid   = 16'($urandom());
    wt    = {7'd0, thits, tid};
    for (int i = 0; i < n_sent && first + i <= 255; i++) begin
      w.tracklet_start = (i == 0);
      w.tracklet_id    = (i == 0) ? tid : 16'($urandom());
      w.tracklet_hits  = (i == 0) ? thits : 8'($urandom());
      w.row            = 8'(first + i);
      w.last_row       = 8'(lrow);
      w.hit_present    = ($urandom_range(99) >= miss_pct);
      w.hit_index      = 16'($urandom());
      // Foreign hits (stored weight above ours) can only get in as shared.
      if ($urandom_range(99) < foreign_pct)
        w.hit_weight = 31'($urandom_range(32'h7FFF_FFFF, 32'(wt) + 1));
      else if ($urandom_range(9) == 0)
        w.hit_weight = wt;
      else
        w.hit_weight = 31'($urandom_range(32'(wt), 0));
      queue_row(w);
    end
  endfunction

  // Mostly well-formed tracklets sized around the current minimum; the rest
  // are cut short, overrun their last row, or are plain random words.
  function automatic void random_tracklet();
    logic [95:0] bits;
    in_word_t    w;
    int          pick;
    int          len;
    int          first;
    pick = $urandom_range(99);
    if (pick < 5) begin
      bits = {$urandom(), $urandom(), $urandom()};
      w    = bits[$bits(in_word_t)-1:0];
      queue_row(w);
      return;
    end
    len = int'(sel_min_hits) + $urandom_range(12, 0);
    if (len > 48) len = 48;
    if (len < 1)  len = 1;
    // Some tracklets sit high so rows past MaxRows and row 255 get hit.
    if ($urandom_range(5) == 0) first = $urandom_range(256 - len, 150);
    else first = $urandom_range(140, 0);
    if (pick < 85)
      add_tracklet(first, len, first + len - 1, $urandom_range(40, 0), $urandom_range(40, 0));
    else if (pick < 93)
      add_tracklet(first, $urandom_range(len, 1), first + len - 1, $urandom_range(40, 0),
                   $urandom_range(40, 0));
    else
      add_tracklet(first, len + $urandom_range(3, 1), first + len - 1, $urandom_range(40, 0),
                   $urandom_range(40, 0));
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CfgMinHits:   sel_min_hits   = val;
      CfgMaxRowGap: sel_max_gap    = val[3:0];
      CfgSharedDiv: sel_shared_div = val;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Idle means: nothing queued or offered, nothing owed, and a DrainCycles wait
  // more for rows that closed nothing but may still be in flight.
  task automatic wait_idle();
    while (row_q.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] mh, input logic [7:0] gap,
                           input logic [7:0] div, input int n_rows,
                           input bit with_hold, input bit no_idle);
    int target;
    wait_idle();
    write_reg(CfgMinHits, mh);
    write_reg(CfgMaxRowGap, gap);
    write_reg(CfgSharedDiv, div);
    steady = no_idle;
    if (with_hold) holds_asked++;
    target = rows_queued + n_rows;
    while (rows_queued < target) random_tracklet();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at the reset register values (min 10, gap 4, divisor 10).
    // Rows before any start run with weight 0: an exact-weight own hit, then
    // a foreign hit that gets in as the first shared one.
    directed_row(1'b0, 16'h0000, 8'h00, 8'd0, 8'd200, 1'b1, 16'h0000, 31'd0);
    directed_row(1'b0, 16'h0000, 8'h00, 8'd1, 8'd200, 1'b1, 16'hFFFF, 31'h7FFF_FFFF);
    // Empty tracklet: nothing until the next start.
    directed_row(1'b1, 16'hFFFF, 8'h00, 8'd2, 8'd200, 1'b1, 16'h0001, 31'd0);
    directed_row(1'b0, 16'h1234, 8'hFF, 8'd3, 8'd200, 1'b1, 16'h0005, 31'd0);
    // Start on a row past its own last row.
    directed_row(1'b1, 16'h0001, 8'h01, 8'd10, 8'd5, 1'b1, 16'h0007, 31'd0);
    // Heaviest tracklet across the MaxRows boundary: ten hits, the first at
    // exactly our weight, the second just above it (shared). From row 160
    // on hits are ignored, the gap runs out and the segment is committed;
    // the last row then finds the minimum out of reach.
    for (int r = 150; r <= 165; r++) begin
      directed_row(r == 150, 16'hFFFF, 8'hFF, 8'(r), 8'd165, 1'b1,
                   (r == 150) ? 16'hFFFF : 16'(r),
                   (r == 150) ? 31'h00FF_FFFF : (r == 151) ? 31'h0100_0000 : 31'd0);
    end

    // Lowest settings: every missed row closes the segment.
    run_phase(8'd1, 8'd0, 8'd1, 110, 1'b0, 1'b0);
    // Highest settings, plus one full-length tracklet that stays alive
    // only while every row brings an accepted hit.
    run_phase(8'd255, 8'd15, 8'd255, 30, 1'b0, 1'b0);
    add_tracklet(0, 30, 255, 0, 0);
    // Out-of-range values: min 0 commits everything, divisor 0 lets every
    // shared hit in once a segment has a hit, gap register upper bits dropped.
    run_phase(8'd0, 8'hFF, 8'd0, 100, 1'b0, 1'b0);
    // Random settings with the receiver holding off long enough to back up
    // into the input.
    run_phase(8'($urandom_range(16, 3)), 8'($urandom()), 8'($urandom_range(255, 1)),
              130, 1'b1, 1'b0);
    // Back to the defaults, both sides running flat out.
    run_phase(MinHitsRst, {4'd0, MaxRowGapRst}, SharedDivRst, 120, 1'b0, 1'b1);
    run_phase(8'($urandom_range(12, 2)), 8'($urandom_range(6, 0)), 8'($urandom_range(20, 1)),
              150, 1'b1, 1'b0);

    wait_idle();

    $display("Covered %0d rows over 7 register settings (%0d register writes), %0d hold-offs",
             rows_accepted, cfg_writes, holds_done);
    $display("Checked %0d results: %0d hits, %0d commits, %0d discards",
             results_seen, hits_seen, commits_seen, discards_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
